// ----- hdl/mau_pkg.sv -----
// Package for the modular arithmetic unit: command codes, widths, FSM state type, datapath command and status types.
// No dependencies.
`default_nettype none
package mau_pkg;
  localparam int unsigned ModulusBits = 31;
  localparam int unsigned OperandBits = 63;
  localparam int unsigned CmdBits     = 3;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_POW = 3'd3,
    CMD_DIV = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DECIDE,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_SHIFT,
    ST_FINAL,
    ST_DONE
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_A_START,
    OP_RED_B_START,
    OP_ADD,
    OP_SUB,
    OP_MUL_AB_START,
    OP_POW_SETUP,
    OP_DIV_SETUP,
    OP_MUL_ACC_START,
    OP_MUL_SQ_START,
    OP_SHIFT,
    OP_DIV_FINAL_START,
    OP_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // reduction or multiply in progress
    logic exp_zero;  // exponent register is zero
    logic exp_lsb;   // current exponent bit
    logic mod_zero;  // modulus is zero
  } dp_status_t;
endpackage
`default_nettype wire

// ----- hdl/mau_datapath.sv -----
// Datapath: operand registers, a shared 1-bit-per-cycle shift-subtract reducer
// and the exponent register. Depends on mau_pkg.
`default_nettype none
module mau_datapath #(
  parameter int unsigned MODULUS_BITS = mau_pkg::ModulusBits
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mau_pkg::dp_cmd_t                  cmd,
  input  wire logic [mau_pkg::CmdBits-1:0]       in_command,
  input  wire logic [mau_pkg::OperandBits-1:0]   in_operand_a,
  input  wire logic [mau_pkg::OperandBits-1:0]   in_operand_b,
  input  wire logic [MODULUS_BITS-1:0]           in_modulus,
  output mau_pkg::dp_status_t                    status,
  output logic [MODULUS_BITS-1:0]                res
);
  import mau_pkg::*;
  localparam int unsigned MB = MODULUS_BITS;
  localparam int unsigned OB = OperandBits;
  localparam int unsigned CW = $clog2(OB + 1);

  logic [MB-1:0] m_r, ar_r, br_r, acc_r, sq_r, res_r;
  logic [OB-1:0] a_r, exp_r;
  // Reducer: remainder of a value shifted in MSB first.
  logic [OB-1:0] src_r;
  logic [MB:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [1:0]    dst_r; // 0:ar 1:br 2:acc 3:sq

  localparam logic [1:0] DstA = 2'd0, DstB = 2'd1, DstAcc = 2'd2, DstSq = 2'd3;

  logic [MB:0]   shl;
  logic [MB:0]   rem_nxt;
  logic [2*MB-1:0] prod;
  logic [MB:0]   sum;

  assign shl = {rem_r[MB-1:0], src_r[OB-1]};
  assign rem_nxt = (shl >= {1'b0, m_r}) ? shl - {1'b0, m_r} : shl;
  assign sum = {1'b0, ar_r} + {1'b0, br_r};

  task automatic start_red(input logic [OB-1:0] v, input logic [CW-1:0] n,
                           input logic [1:0] d);
    src_r  <= v;
    rem_r  <= '0;
    cnt_r  <= n;
    busy_r <= 1'b1;
    dst_r  <= d;
  endtask

  // Product is registered before it enters the reducer.
  logic [MB-1:0] mx, my;
  logic [2*MB-1:0] prod_r;
  logic          mul_pend_r;
  logic [1:0]    mul_dst_r;
  assign prod = mx * my;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      mul_pend_r <= 1'b0;
    end else begin
      if (mul_pend_r) begin
        mul_pend_r <= 1'b0;
        // Align the product to the top so it shifts out MSB first.
        start_red({prod_r, {(OB-2*MB){1'b0}}}, CW'(2*MB), mul_dst_r);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        src_r <= {src_r[OB-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          unique case (dst_r)
            DstA:   ar_r  <= rem_nxt[MB-1:0];
            DstB:   br_r  <= rem_nxt[MB-1:0];
            DstAcc: acc_r <= rem_nxt[MB-1:0];
            default: sq_r <= rem_nxt[MB-1:0];
          endcase
        end
      end
      unique case (cmd.op)
        OP_LOAD: begin
          a_r   <= in_operand_a;
          exp_r <= in_operand_b;
          m_r   <= in_modulus;
        end
        OP_RED_A_START: start_red(a_r, CW'(OB), DstA);
        OP_RED_B_START: start_red(exp_r, CW'(OB), DstB);
        OP_ADD: res_r <= (sum >= {1'b0, m_r}) ? MB'(sum - {1'b0, m_r}) : sum[MB-1:0];
        OP_SUB: res_r <= (ar_r >= br_r) ? MB'(ar_r - br_r) : MB'(ar_r + m_r - br_r);
        OP_MUL_AB_START: begin
          prod_r <= prod; mul_pend_r <= 1'b1; mul_dst_r <= DstAcc;
        end
        OP_POW_SETUP: begin
          acc_r <= MB'(1);
          sq_r  <= ar_r;
        end
        OP_DIV_SETUP: begin
          acc_r <= MB'(1);
          sq_r  <= br_r;
          exp_r <= (m_r >= MB'(2)) ? OB'(m_r - MB'(2)) : '0;
        end
        OP_MUL_ACC_START: begin
          prod_r <= prod; mul_pend_r <= 1'b1; mul_dst_r <= DstAcc;
        end
        OP_MUL_SQ_START: begin
          prod_r <= prod; mul_pend_r <= 1'b1; mul_dst_r <= DstSq;
        end
        OP_SHIFT: exp_r <= exp_r >> 1;
        OP_DIV_FINAL_START: begin
          prod_r <= prod; mul_pend_r <= 1'b1; mul_dst_r <= DstAcc;
        end
        OP_ZERO: res_r <= '0;
        default: ;
      endcase
    end
  end

  // Multiplier operand select.
  always_comb begin
    unique case (cmd.op)
      OP_MUL_AB_START:    begin mx = ar_r;  my = br_r; end
      OP_MUL_ACC_START:   begin mx = acc_r; my = sq_r; end
      OP_MUL_SQ_START:    begin mx = sq_r;  my = sq_r; end
      OP_DIV_FINAL_START: begin mx = ar_r;  my = acc_r; end
      default:            begin mx = '0;    my = '0; end
    endcase
  end

  assign status.busy     = busy_r | mul_pend_r;
  assign status.exp_zero = (exp_r == '0);
  assign status.exp_lsb  = exp_r[0];
  assign status.mod_zero = (m_r == '0);
  // Power with zero exponent returns acc=1 unreduced; others read res or acc.
  assign res = (in_command == CMD_ADD || in_command == CMD_SUB) ? res_r : acc_r;
endmodule
`default_nettype wire

// ----- hdl/mau_ctrl.sv -----
// Controller FSM: sequences reductions and square-and-multiply steps.
// Depends on mau_pkg.
`default_nettype none
module mau_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [mau_pkg::CmdBits-1:0]  in_command,
  output logic                              in_stall,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mau_pkg::CmdBits-1:0]       cmd_q,
  output mau_pkg::dp_cmd_t                  dcmd,
  input  wire mau_pkg::dp_status_t          status
);
  import mau_pkg::*;
  state_t state_r, state_nxt;
  logic [CmdBits-1:0] cmd_r, cmd_nxt;
  logic bad_r, bad_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cmd_r   <= '0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign cmd_q = bad_r ? CMD_ADD : cmd_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    bad_nxt   = bad_r;
    dcmd.op   = OP_NONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // Hold off the sender while reset is applied.
        in_stall = !rst_n;
        if (in_valid) begin
          dcmd.op   = OP_LOAD;
          cmd_nxt   = in_command;
          bad_nxt   = 1'b0;
          state_nxt = ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (status.mod_zero || cmd_r > CMD_DIV) begin
          dcmd.op = OP_ZERO; bad_nxt = 1'b1; state_nxt = ST_DONE;
        end else begin
          dcmd.op = OP_RED_A_START; state_nxt = ST_RED_B;
        end
      end
      ST_RED_B: if (!status.busy) begin
        dcmd.op = OP_RED_B_START; state_nxt = ST_DECIDE;
      end
      ST_DECIDE: if (!status.busy) begin
        unique case (cmd_r)
          CMD_ADD: begin dcmd.op = OP_ADD; state_nxt = ST_DONE; end
          CMD_SUB: begin dcmd.op = OP_SUB; state_nxt = ST_DONE; end
          CMD_MUL: begin dcmd.op = OP_MUL_AB_START; state_nxt = ST_FINAL; end
          CMD_POW: begin dcmd.op = OP_POW_SETUP; state_nxt = ST_MUL_ACC; end
          default: begin dcmd.op = OP_DIV_SETUP; state_nxt = ST_MUL_ACC; end
        endcase
      end
      ST_MUL_ACC: if (!status.busy) begin
        if (status.exp_zero) begin
          if (cmd_r == CMD_DIV) begin
            dcmd.op = OP_DIV_FINAL_START; state_nxt = ST_FINAL;
          end else state_nxt = ST_DONE;
        end else begin
          if (status.exp_lsb) dcmd.op = OP_MUL_ACC_START;
          state_nxt = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: if (!status.busy) begin
        dcmd.op = OP_MUL_SQ_START; state_nxt = ST_SHIFT;
      end
      ST_SHIFT: if (!status.busy) begin
        dcmd.op = OP_SHIFT; state_nxt = ST_MUL_ACC;
      end
      ST_FINAL: if (!status.busy) state_nxt = ST_DONE;
      ST_DONE: begin
        out_valid = rst_n;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/modular_arithmetic_unit.sv -----
// Top level of the modular arithmetic unit: controller plus datapath.
// Depends on mau_pkg, mau_ctrl, mau_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall) transfers command, operand_a,
//   operand_b and modulus. Result channel (out_valid/out_stall) transfers
//   one residue per item. One item is processed at a time; in_stall is high
//   from acceptance until the cycle after the result transfer.
// Operation:
//   Each operand reduction is bit serial over the 63-bit operand, one bit
//   per cycle through the shared shift-subtract reducer. Each modular
//   product is registered from the multiplier, loaded into the reducer and
//   reduced. Power is computed by square-and-multiply over the exponent
//   bits. Divide raises to modulus - 2 (31 bits) and ends with one more
//   product. A zero modulus or an unused command gives a zero result. The
//   next item can transfer in the cycle after the result; the shared
//   reducer sets the rate.
// Reset:
//   Synchronous active-low rst_n returns the controller to idle; any item
//   in flight is dropped and both channels hold off while rst_n is low.
//   A stalled result holds until transferred.
`default_nettype none
module modular_arithmetic_unit #(
  parameter int unsigned MODULUS_BITS = mau_pkg::ModulusBits
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [mau_pkg::CmdBits-1:0]      in_command,
  input  wire logic [mau_pkg::OperandBits-1:0]  in_operand_a,
  input  wire logic [mau_pkg::OperandBits-1:0]  in_operand_b,
  input  wire logic [MODULUS_BITS-1:0]          in_modulus,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [MODULUS_BITS-1:0]               out_result
);
  import mau_pkg::*;
  dp_cmd_t    dcmd;
  dp_status_t status;
  logic [CmdBits-1:0] cmd_q;

  mau_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_command, .in_stall,
    .out_valid, .out_stall, .cmd_q, .dcmd, .status
  );

  mau_datapath #(.MODULUS_BITS(MODULUS_BITS)) u_dp (
    .clk, .rst_n, .cmd(dcmd), .in_command(cmd_q),
    .in_operand_a, .in_operand_b, .in_modulus, .status, .res(out_result)
  );
endmodule
`default_nettype wire

// ----- hdl/mau_checker.sv -----
// Port-level checker for the modular arithmetic unit, bound to the top level.
// Depends on mau_pkg.
`default_nettype none
module mau_checker #(
  parameter int unsigned MODULUS_BITS = mau_pkg::ModulusBits
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [MODULUS_BITS-1:0] out_result
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("result dropped while stalled");
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("not busy after transfer");
endmodule

bind modular_arithmetic_unit mau_checker #(.MODULUS_BITS(MODULUS_BITS)) u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_result
);
`default_nettype wire
